// ===== src/ibhc_pkg.sv =====
// Shared types and constants of the bed height compensation block.
package ibhc_pkg;

  localparam int MAX_POINTS = 512;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Divider sizes: normalized distance, weight and final mean
  localparam int DIST_NUM_W = 49;
  localparam int DIST_DEN_W = 31;
  localparam int DIST_Q_W   = 34;
  localparam int WGT_NUM_W  = 53;
  localparam int WGT_DEN_W  = 50;
  localparam int WGT_Q_W    = 34;
  localparam int WSUM_W     = WGT_Q_W + CNT_W;
  localparam int ACC_W      = WGT_Q_W + 32 + CNT_W;
  localparam int MEAN_Q_W   = 33;
  localparam int STEP_W     = 6;

  localparam logic [WGT_DEN_W-1:0] EPS_Q32    = WGT_DEN_W'(429497);
  localparam logic [24:0]          DIST_LIMIT = 25'h1000000;
  localparam logic [30:0]          ONE_Q16    = 31'd65536;
  localparam logic [30:0]          HALF_SIZE_RESET = 31'd19660800;

  // Operation codes
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_COMP    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_BED_HALF_SIZE = 2'd0;
  localparam logic [1:0] REG_PROBE_HEIGHT  = 2'd1;

  typedef struct packed {
    logic [1:0]   operation;
    logic [31:0]  x_coord;
    logic [31:0]  y_coord;
    logic [31:0]  z_coord;
    logic [31:0]  probe_reading;
    logic         invert;
  } in_item_t;

  typedef struct packed {
    logic [31:0]  z_result;
    logic [31:0]  height_offset;
    logic [9:0]   point_count;
    logic         table_full;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD,
    ST_DLOAD,
    ST_DDIV,
    ST_SQ,
    ST_WLOAD,
    ST_WDIV,
    ST_MUL,
    ST_ACC,
    ST_FLOAD,
    ST_FDIV,
    ST_ROUND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic wr_point;
    logic cnt_inc;
    logic cnt_clr;
    logic set_full;
    logic idx_clr;
    logic idx_next;
    logic dist_load;
    logic dist_step;
    logic sq;
    logic wdiv_load;
    logic wdiv_step;
    logic mul;
    logic acc;
    logic fdiv_load;
    logic fdiv_step;
    logic round;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       table_empty;
    logic       table_full;
    logic       last_point;
    logic       out_free;
  } status_t;

endpackage

// ===== src/ibhc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ibhc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ibhc_div.sv =====
// Restoring divider, one quotient bit per cycle while step is high.
module ibhc_div #(
  parameter int NUM_W = 49,
  parameter int DEN_W = 31,
  parameter int Q_W   = 34
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quot,
  output logic [DEN_W-1:0] rem
);

  logic [DEN_W-1:0] r;
  logic [DEN_W-1:0] d;
  logic [Q_W-1:0]   sh;
  logic [DEN_W:0]   trial;
  logic             fits;

  assign trial = {r, sh[Q_W-1]};
  assign fits  = trial >= {1'b0, d};

  // Load the upper dividend bits, then shift one bit in per step
  always_ff @(posedge clk) begin
    if (load) begin
      r  <= DEN_W'(num >> Q_W);
      sh <= num[Q_W-1:0];
      d  <= den;
    end else if (step) begin
      r  <= fits ? DEN_W'(trial - {1'b0, d}) : DEN_W'(trial);
      sh <= {sh[Q_W-2:0], fits};
    end
  end

  assign quot = sh;
  assign rem  = r;

endmodule

// ===== src/ibhc_ctrl.sv =====
// Sequencer of the bed height compensation block.
module ibhc_ctrl import ibhc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t stat,
  output cmd_t    cmd
);

  state_t            state, state_next;
  logic [STEP_W-1:0] step;
  logic              div_state;

  assign div_state = (state == ST_DDIV) || (state == ST_WDIV) || (state == ST_FDIV);

  // State and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= div_state ? step + 1'b1 : '0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_EXEC;
      ST_EXEC: begin
        if (stat.op == OP_COMP && !stat.table_empty) state_next = ST_RD;
        else state_next = ST_DONE;
      end
      ST_RD:    state_next = ST_DLOAD;
      ST_DLOAD: state_next = ST_DDIV;
      ST_DDIV:  if (step == STEP_W'(DIST_Q_W - 1)) state_next = ST_SQ;
      ST_SQ:    state_next = ST_WLOAD;
      ST_WLOAD: state_next = ST_WDIV;
      ST_WDIV:  if (step == STEP_W'(WGT_Q_W - 1)) state_next = ST_MUL;
      ST_MUL:   state_next = ST_ACC;
      ST_ACC:   state_next = stat.last_point ? ST_FLOAD : ST_RD;
      ST_FLOAD: state_next = ST_FDIV;
      ST_FDIV:  if (step == STEP_W'(MEAN_Q_W - 1)) state_next = ST_ROUND;
      ST_ROUND: state_next = ST_DONE;
      ST_DONE:  if (stat.out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:  cmd.load_in = in_valid;
      ST_EXEC: begin
        unique case (stat.op)
          OP_ADD: begin
            cmd.set_full = stat.table_full;
            cmd.wr_point = !stat.table_full;
            cmd.cnt_inc  = !stat.table_full;
          end
          OP_CLEAR: cmd.cnt_clr = 1'b1;
          OP_COMP:  cmd.idx_clr = 1'b1;
          default:  cmd = '0;
        endcase
      end
      ST_DLOAD: cmd.dist_load = 1'b1;
      ST_DDIV:  cmd.dist_step = 1'b1;
      ST_SQ:    cmd.sq        = 1'b1;
      ST_WLOAD: cmd.wdiv_load = 1'b1;
      ST_WDIV:  cmd.wdiv_step = 1'b1;
      ST_MUL:   cmd.mul       = 1'b1;
      ST_ACC: begin
        cmd.acc      = 1'b1;
        cmd.idx_next = !stat.last_point;
      end
      ST_FLOAD: cmd.fdiv_load = 1'b1;
      ST_FDIV:  cmd.fdiv_step = 1'b1;
      ST_ROUND: cmd.round     = 1'b1;
      ST_DONE:  cmd.out_load  = stat.out_free;
      default:  cmd = '0;
    endcase
  end

  assign in_stall = (state != ST_IDLE);

  // A divide phase never runs past the widest quotient's bit count
  assert property (@(posedge clk) disable iff (rst)
    div_state |-> step < STEP_W'(DIST_Q_W))
    else $error("divider step count overrun");

  // An accepted request holds off the next one
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while busy");

  // A result is loaded only at the end of a request
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (state == ST_DONE) && stat.out_free)
    else $error("result loaded out of turn");

endmodule

// ===== src/ibhc_dp.sv =====
// Datapath: point table, distance and weight dividers, accumulators, result.
module ibhc_dp import ibhc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     stat,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [30:0]             bed_half_size;
  logic [31:0]             probe_height;
  in_item_t                item;
  logic [CNT_W-1:0]        count;
  logic [ADDR_W-1:0]       idx;
  logic                    full_flag;
  logic [31:0]             offset;
  logic [31:0]             rd_x, rd_y, rd_h, h_reg;
  logic [33:0]             hs;
  logic [31:0]             h_sat;
  logic [30:0]             size;
  logic [32:0]             dx, dy, mag_x, mag_y;
  logic [DIST_Q_W-1:0]     qx, qy;
  logic [24:0]             sat_x, sat_y;
  logic [WGT_DEN_W-1:0]    sqx, sqy;
  logic [WGT_Q_W-1:0]      w;
  logic [63:0]             plo;
  logic [33:0]             phi;
  logic [ACC_W-1:0]        acc;
  logic [WSUM_W-1:0]       wsum;
  logic [MEAN_Q_W-1:0]     fq;
  logic [WSUM_W-1:0]       frem;
  logic                    up;
  logic [33:0]             qr;
  logic [32:0]             zs;
  logic [31:0]             z_sat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bed_half_size <= HALF_SIZE_RESET;
      probe_height  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_BED_HALF_SIZE) bed_half_size <= cfg_data[30:0];
      if (cfg_index == REG_PROBE_HEIGHT)  probe_height  <= cfg_data;
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.load_in) item <= in_data;
  end

  // Point count, walk index, refusal flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_clr) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) idx <= '0;
    else if (cmd.idx_next) idx <= idx + 1'b1;
    if (cmd.load_in) full_flag <= 1'b0;
    else if (cmd.set_full) full_flag <= 1'b1;
  end

  // Stored height: z minus probe reading minus probe height, saturated
  assign hs = {{2{item.z_coord[31]}}, item.z_coord}
            - {{2{item.probe_reading[31]}}, item.probe_reading}
            - {{2{probe_height[31]}}, probe_height};
  assign h_sat = (hs[33:31] == 3'b000 || hs[33:31] == 3'b111) ? hs[31:0]
               : (hs[33] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  ibhc_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk(clk), .we(cmd.wr_point), .waddr(count[ADDR_W-1:0]),
    .wdata(item.x_coord), .raddr(idx), .rdata(rd_x));
  ibhc_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk(clk), .we(cmd.wr_point), .waddr(count[ADDR_W-1:0]),
    .wdata(item.y_coord), .raddr(idx), .rdata(rd_y));
  ibhc_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_h (
    .clk(clk), .we(cmd.wr_point), .waddr(count[ADDR_W-1:0]),
    .wdata(h_sat), .raddr(idx), .rdata(rd_h));

  // Distance magnitudes; the sign drops out of the square
  assign size  = (bed_half_size < ONE_Q16) ? ONE_Q16 : bed_half_size;
  assign dx    = {rd_x[31], rd_x} - {item.x_coord[31], item.x_coord};
  assign dy    = {rd_y[31], rd_y} - {item.y_coord[31], item.y_coord};
  assign mag_x = dx[32] ? 33'(-dx) : dx;
  assign mag_y = dy[32] ? 33'(-dy) : dy;

  ibhc_div #(.NUM_W(DIST_NUM_W), .DEN_W(DIST_DEN_W), .Q_W(DIST_Q_W)) u_div_x (
    .clk(clk), .load(cmd.dist_load), .step(cmd.dist_step),
    .num({mag_x, 16'd0}), .den(size), .quot(qx), .rem());
  ibhc_div #(.NUM_W(DIST_NUM_W), .DEN_W(DIST_DEN_W), .Q_W(DIST_Q_W)) u_div_y (
    .clk(clk), .load(cmd.dist_load), .step(cmd.dist_step),
    .num({mag_y, 16'd0}), .den(size), .quot(qy), .rem());

  // Clamp to 256 half-sizes and square
  assign sat_x = (qx > DIST_Q_W'(DIST_LIMIT)) ? DIST_LIMIT : qx[24:0];
  assign sat_y = (qy > DIST_Q_W'(DIST_LIMIT)) ? DIST_LIMIT : qy[24:0];

  always_ff @(posedge clk) begin
    if (cmd.dist_load) h_reg <= rd_h;
    if (cmd.sq) begin
      sqx <= WGT_DEN_W'(sat_x) * WGT_DEN_W'(sat_x);
      sqy <= WGT_DEN_W'(sat_y) * WGT_DEN_W'(sat_y);
    end
  end

  // Weight: 2^52 over the squared distance plus epsilon
  ibhc_div #(.NUM_W(WGT_NUM_W), .DEN_W(WGT_DEN_W), .Q_W(WGT_Q_W)) u_div_w (
    .clk(clk), .load(cmd.wdiv_load), .step(cmd.wdiv_step),
    .num({1'b1, 52'd0}), .den(sqx + sqy + EPS_Q32), .quot(w), .rem());

  // Weighted biased height and running sums
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      plo <= 64'(w[31:0]) * 64'({~h_reg[31], h_reg[30:0]});
      phi <= 34'(w[33:32]) * 34'({~h_reg[31], h_reg[30:0]});
    end
    if (cmd.idx_clr) begin
      acc  <= '0;
      wsum <= '0;
    end else if (cmd.acc) begin
      acc  <= acc + ACC_W'(plo) + ACC_W'({phi, 32'd0});
      wsum <= wsum + WSUM_W'(w);
    end
  end

  // Mean: sum of weighted heights over sum of weights
  ibhc_div #(.NUM_W(ACC_W), .DEN_W(WSUM_W), .Q_W(MEAN_Q_W)) u_div_mean (
    .clk(clk), .load(cmd.fdiv_load), .step(cmd.fdiv_step),
    .num(acc), .den(wsum), .quot(fq), .rem(frem));

  // Round to nearest, ties up, and remove the bias
  assign up = {frem, 1'b0} >= {1'b0, wsum};
  assign qr = 34'(fq) + 34'(up);

  always_ff @(posedge clk) begin
    if (cmd.load_in) offset <= '0;
    else if (cmd.round) offset <= (qr[33] || qr[32]) ? 32'h7FFF_FFFF
                                                     : {~qr[31], qr[30:0]};
  end

  // Compensated z, saturated
  assign zs = item.invert ? {item.z_coord[31], item.z_coord} - {offset[31], offset}
                          : {item.z_coord[31], item.z_coord} + {offset[31], offset};
  assign z_sat = (zs[32] == zs[31]) ? zs[31:0]
               : (zs[32] ? 32'h8000_0000 : 32'h7FFF_FFFF);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.z_result      <= z_sat;
      out_data.height_offset <= offset;
      out_data.point_count   <= 10'(count);
      out_data.table_full    <= full_flag;
    end
  end

  // Status to the sequencer
  assign stat.op          = item.operation;
  assign stat.table_empty = (count == '0);
  assign stat.table_full  = (count == CNT_W'(MAX_POINTS));
  assign stat.last_point  = ({1'b0, idx} == CNT_W'(count - 1'b1));
  assign stat.out_free    = !out_valid || !out_stall;

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond table size");

  assert property (@(posedge clk) disable iff (rst)
    cmd.wr_point |-> count < CNT_W'(MAX_POINTS))
    else $error("point written into a full table");

  assert property (@(posedge clk) disable iff (rst)
    cmd.fdiv_load |-> wsum != '0)
    else $error("mean divide with zero weight sum");

endmodule

// ===== src/idw_bed_height_compensation_top.sv =====
// Top level of the inverse distance weighted bed height compensation block.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_stall  | in_data  (operation, x, y, z, reading, invert)
//  out     | out_valid / out_stall| out_data (z_result, offset, count, full)
//  cfg     | cfg_we               | cfg_index, cfg_data
//
// Add, clear and unused requests go straight from execute to done; compensate
// runs the per-point distance and weight dividers for each of the N stored
// points (one quotient bit a cycle), then the final mean divider.
// Reset (rst, synchronous) empties the table and restores the registers.
// The block takes a request while a result waits; a stalled result holds
// the next one in the done state until the output register frees.
module idw_bed_height_compensation_top import ibhc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t    cmd;
  status_t stat;

  ibhc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd));

  ibhc_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data));

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the inverse distance weighted bed height compensation block.
`timescale 1ns / 100ps

module tb;
  import ibhc_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int         SETTLE_CYC  = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  idw_bed_height_compensation_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the point table and registers
  logic signed [31:0] tbl_x [MAX_POINTS];
  logic signed [31:0] tbl_y [MAX_POINTS];
  logic signed [31:0] tbl_h [MAX_POINTS];
  int unsigned        tbl_count = 0;
  logic [30:0]        half_size = HALF_SIZE_RESET;
  logic signed [31:0] probe_off = '0;

  in_item_t  req_q [$];
  out_item_t answer_q [$];
  int        mismatches = 0;
  int        n_results = 0;
  int        n_comp = 0;
  int        n_refused = 0;
  logic      in_fired = 1'b0;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint norm_axis(logic signed [31:0] p, logic signed [31:0] t,
                                       longint sz);
    longint n;
    n = ((longint'(p) - longint'(t)) * 65536) / sz;
    if (n > 64'sd16777216) n = 64'sd16777216;
    if (n < -64'sd16777216) n = -64'sd16777216;
    return n;
  endfunction

  // Weighted mean of stored heights, weights 2^52 / (nx^2 + ny^2 + eps)
  function automatic logic signed [31:0] mean_height(logic signed [31:0] tx,
                                                      logic signed [31:0] ty);
    longint       sz, nx, ny;
    logic [63:0]  dist2, wgt, wsum, hb;
    logic [127:0] acc, quo, rmd;
    sz = (half_size < ONE_Q16) ? 64'sd65536 : longint'({33'd0, half_size});
    acc = '0;
    wsum = '0;
    if (tbl_count == 0) return '0;
    for (int i = 0; i < tbl_count; i++) begin
      nx = norm_axis(tbl_x[i], tx, sz);
      ny = norm_axis(tbl_y[i], ty, sz);
      dist2 = nx * nx + ny * ny + 64'd429497;
      wgt = (64'd1 << 52) / dist2;
      hb = longint'(tbl_h[i]) + 64'sd2147483648;
      acc += {64'd0, wgt} * {64'd0, hb};
      wsum += wgt;
    end
    quo = acc / {64'd0, wsum};
    rmd = acc % {64'd0, wsum};
    if ((rmd << 1) >= {64'd0, wsum}) quo++;
    return clamp32(longint'({31'd0, quo[32:0]}) - 64'sd2147483648);
  endfunction

  // Apply one request to the shadow table and return its answer
  function automatic out_item_t predict_answer(in_item_t r);
    out_item_t a;
    logic signed [31:0] ofs;
    a = '0;
    a.z_result = r.z_coord;
    case (r.operation)
      OP_ADD: begin
        if (tbl_count >= MAX_POINTS) begin
          a.table_full = 1'b1;
        end else begin
          tbl_x[tbl_count] = r.x_coord;
          tbl_y[tbl_count] = r.y_coord;
          tbl_h[tbl_count] = clamp32(longint'($signed(r.z_coord))
                                     - longint'($signed(r.probe_reading))
                                     - longint'(probe_off));
          tbl_count++;
        end
      end
      OP_COMP: begin
        ofs = mean_height(r.x_coord, r.y_coord);
        a.height_offset = ofs;
        a.z_result = r.invert ? clamp32(longint'($signed(r.z_coord)) - longint'(ofs))
                              : clamp32(longint'($signed(r.z_coord)) + longint'(ofs));
      end
      OP_CLEAR: tbl_count = 0;
      default: ;
    endcase
    a.point_count = tbl_count[9:0];
    return a;
  endfunction

  // Predict on accepted requests, track register writes, check answers
  always @(posedge clk) begin
    out_item_t want;
    in_fired <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_index == REG_BED_HALF_SIZE) half_size = cfg_data[30:0];
        else if (cfg_index == REG_PROBE_HEIGHT) probe_off = cfg_data;
      end
      if (in_valid && !in_stall) begin
        if (in_data.operation == OP_COMP) n_comp++;
        answer_q.push_back(predict_answer(in_data));
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (out_data.table_full) n_refused++;
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected answer %p", out_data);
        end else begin
          want = answer_q.pop_front();
          if (out_data.z_result !== want.z_result ||
              out_data.height_offset !== want.height_offset ||
              out_data.point_count !== want.point_count ||
              out_data.table_full !== want.table_full) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch at answer %0d: expected z=%h ofs=%h cnt=%0d full=%b,",
                        " got z=%h ofs=%h cnt=%0d full=%b"},
                       n_results, want.z_result, want.height_offset, want.point_count,
                       want.table_full, out_data.z_result, out_data.height_offset,
                       out_data.point_count, out_data.table_full);
          end
        end
      end
    end
  end

  // Request driver: bursts of random length with random gaps
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_fired || !in_valid) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (req_q.size() > 0) begin
        in_data <= req_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Answer stall pattern, with one long hold-off to back the block up
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   run_left = 0;
  int   stall_mode = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_results >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 3000;
      out_stall <= 1'b1;
    end else begin
      if (run_left == 0) begin
        run_left <= $urandom_range(1, 40);
        stall_mode <= $urandom_range(0, 3);
      end else begin
        run_left <= run_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= 1'b1;
        2: out_stall <= $urandom_range(0, 1);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 200) * 32'd65536 - 32'd6553600;
      default: return $urandom_range(0, 39321600) - 32'd19660800;
    endcase
  endfunction

  function automatic logic [31:0] pick_height();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 1310720) - 32'd655360;
  endfunction

  task automatic push_req(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z, logic [31:0] rd, logic inv);
    in_item_t r;
    r.operation = op;
    r.x_coord = x;
    r.y_coord = y;
    r.z_coord = z;
    r.probe_reading = rd;
    r.invert = inv;
    req_q.push_back(r);
  endtask

  task automatic wait_drained();
    while (req_q.size() > 0 || in_valid || answer_q.size() > 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus
  initial begin
    logic [31:0] sizes [6];
    logic [31:0] probes [5];
    logic [31:0] px, py;
    int issued, nadd, ncomp, phase;
    sizes = '{32'd0, 32'd65536, 32'h7FFFFFFF, 32'd19660800, 32'hFFFFFFFF, 32'd3276800};
    probes = '{32'd0, 32'h80000000, 32'h7FFFFFFF, 32'd65536, 32'hFFFF0000};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, unused op, saturating heights, exact hits
    push_req(OP_COMP, 32'h12345678, 32'h0, 32'h7FFFFFFF, '1, 1'b0);
    push_req(OP_UNUSED, '1, '1, 32'h80000000, '1, 1'b1);
    push_req(OP_CLEAR, '0, '0, 32'h00010000, '0, 1'b0);
    push_req(OP_ADD, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0);
    push_req(OP_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1'b1);
    push_req(OP_ADD, '0, '0, 32'h00030000, 32'h00010000, 1'b0);
    push_req(OP_COMP, '0, '0, 32'h7FFFFFF0, '0, 1'b0);
    push_req(OP_COMP, '0, '0, 32'h80000010, '0, 1'b1);
    push_req(OP_COMP, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, '0, 1'b0);
    push_req(OP_COMP, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, '1, 1'b1);
    push_req(OP_COMP, 32'h00640000, 32'hFF9C0000, 32'h00050000, '0, 1'b1);
    push_req(OP_UNUSED, 32'h1, 32'h2, 32'h3, 32'h4, 1'b0);
    push_req(OP_CLEAR, '1, '1, '1, '1, 1'b1);
    push_req(OP_COMP, 32'h1, 32'h1, 32'h12340000, '0, 1'b1);
    wait_drained();

    // Fill the table past capacity, then interpolate over all of it
    push_req(OP_CLEAR, '0, '0, '0, '0, 1'b0);
    for (int i = 0; i < MAX_POINTS + 3; i++)
      push_req(OP_ADD, pick_coord(), pick_coord(), pick_height(), pick_height(), 1'b0);
    push_req(OP_COMP, pick_coord(), pick_coord(), pick_height(), '0, 1'b0);
    push_req(OP_COMP, pick_coord(), pick_coord(), pick_height(), '0, 1'b1);
    push_req(OP_CLEAR, '0, '0, '0, '0, 1'b0);
    wait_drained();

    // Random phases, each under its own register setting
    issued = 0;
    phase = 0;
    while (issued < 470) begin
      write_reg(REG_BED_HALF_SIZE, (phase < 6) ? sizes[phase] :
                ($urandom_range(0, 1) ? sizes[$urandom_range(0, 5)] : $urandom));
      write_reg(REG_PROBE_HEIGHT, (phase < 5) ? probes[phase] :
                ($urandom_range(0, 1) ? probes[$urandom_range(0, 4)] : $urandom));
      write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
      if ($urandom_range(0, 4) != 0) begin
        push_req(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
        issued++;
      end
      nadd = $urandom_range(0, 24);
      px = pick_coord();
      py = pick_coord();
      for (int i = 0; i < nadd; i++) begin
        px = pick_coord();
        py = pick_coord();
        push_req(OP_ADD, px, py, pick_height(), pick_height(), $urandom_range(0, 1));
        issued++;
      end
      ncomp = $urandom_range(1, 8);
      for (int i = 0; i < ncomp; i++) begin
        case ($urandom_range(0, 9))
          0: push_req(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
          1: push_req(OP_ADD, pick_coord(), pick_coord(), $urandom, $urandom, 1'b0);
          2: push_req(OP_COMP, px, py, pick_height(), $urandom, $urandom_range(0, 1));
          3: push_req(OP_COMP, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
          default: push_req(OP_COMP, pick_coord(), pick_coord(), pick_height(), $urandom,
                            $urandom_range(0, 1));
        endcase
        issued++;
      end
      wait_drained();
      phase++;
    end

    // Let any late answer show up, then judge
    repeat (SETTLE_CYC) @(posedge clk);
    $display("covered %0d answers, %0d interpolations, %0d refused adds over %0d settings",
             n_results, n_comp, n_refused, phase + 2);
    if (mismatches == 0 && answer_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("timeout with %0d answers outstanding", answer_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== idw_bed_height_compensation_top.f =====
src/ibhc_pkg.sv
src/ibhc_ram.sv
src/ibhc_div.sv
src/ibhc_ctrl.sv
src/ibhc_dp.sv
src/idw_bed_height_compensation_top.sv
verif/tb.sv
